### rtl/otset_pkg.sv
// Package for the ordered task set: beat types of both channels and opcode codes.
// Depends on nothing; imported by otset_seq, ordered_task_set_top, otset_checker and the testbench.
package otset_pkg;

    localparam logic [2:0] OP_PUSH_HEAD = 3'd0;
    localparam logic [2:0] OP_PUSH_TAIL = 3'd1;
    localparam logic [2:0] OP_REMOVE    = 3'd2;
    localparam logic [2:0] OP_ROTATE    = 3'd3;
    localparam logic [2:0] OP_QUERY     = 3'd4;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] task_id;
    } t_in;

    typedef struct packed {
        logic       was_present;
        logic       changed;
        logic       full_reject;
        logic       head_valid;
        logic [7:0] head_task;
        logic [4:0] entry_count;
    } t_out;

endpackage

### rtl/otset_ram.sv
// Entry store of the ordered task set: one write port, one registered read port.
// No dependencies; instantiated by ordered_task_set_top.
module otset_ram #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 8
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [ID_BITS-1:0]       i_wdata,
    output logic [ID_BITS-1:0]       o_rdata
);

    logic [ID_BITS-1:0] r_mem [DEPTH];
    logic [ID_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/otset_seq.sv
// Sequencer of the ordered task set: scan, decide, shift and tail write over the entry store.
// Uses otset_pkg for beat types and opcodes; drives otset_ram through the top level.
module otset_seq #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  otset_pkg::t_in           i_item,
    input  logic                     i_res_free,
    output logic                     o_busy,
    output logic                     o_done,
    output otset_pkg::t_out          o_res,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  logic [ID_BITS-1:0]       i_rdata,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [ID_BITS-1:0]       o_wdata
);
    import otset_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_TAIL   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0]         r_state,   n_state;
    logic [2:0]         r_op,      n_op;
    logic [ID_BITS-1:0] r_t,       n_t;
    logic [CW-1:0]      r_count,   n_count;
    logic [ID_BITS-1:0] r_head,    n_head;
    logic [CW-1:0]      r_idx,     n_idx;
    logic               r_pend,    n_pend;
    logic [AW-1:0]      r_paddr,   n_paddr;
    logic               r_found,   n_found;
    logic [AW-1:0]      r_pos,     n_pos;
    logic [AW-1:0]      r_src,     n_src;
    logic [CW-1:0]      r_left,    n_left;
    logic               r_up,      n_up;
    logic               r_present, n_present;
    logic               r_changed, n_changed;
    logic               r_reject,  n_reject;

    logic [39:0]        tid_ext;
    logic [39:0]        head_ext;
    logic [31:0]        cnt_ext;
    logic [CW-1:0]      cnt_m1;
    logic               hit;

    assign tid_ext  = 40'(i_item.task_id);
    assign head_ext = 40'(r_head);
    assign cnt_ext  = 32'(r_count);
    assign cnt_m1   = r_count - CW'(1);
    // scan compare: stored entry against the task under test
    assign hit      = r_pend && (i_rdata == r_t);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_t       = r_t;
        n_count   = r_count;
        n_head    = r_head;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_paddr   = r_paddr;
        n_found   = r_found;
        n_pos     = r_pos;
        n_src     = r_src;
        n_left    = r_left;
        n_up      = r_up;
        n_present = r_present;
        n_changed = r_changed;
        n_reject  = r_reject;
        o_raddr   = r_src;
        o_we      = 1'b0;
        o_waddr   = r_paddr;
        o_wdata   = i_rdata;

        case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
                if (i_start) begin
                    n_op      = i_item.opcode;
                    n_t       = tid_ext[ID_BITS-1:0];
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_present = 1'b0;
                    n_changed = 1'b0;
                    n_reject  = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_pos   = r_paddr;
                end
                if (r_idx < r_count) begin
                    o_raddr = r_idx[AW-1:0];
                    n_paddr = r_idx[AW-1:0];
                    n_pend  = 1'b1;
                    n_idx   = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                n_present = r_found;
                n_state   = S_RESP;
                case (r_op)
                    OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                        if (!r_found) begin
                            if (r_count == CW'(DEPTH)) begin
                                n_reject = 1'b1;
                            end else if (r_op == OP_PUSH_HEAD) begin
                                n_changed = 1'b1;
                                n_up      = 1'b1;
                                n_src     = cnt_m1[AW-1:0];
                                n_left    = r_count;
                                n_state   = S_MOVE;
                            end else begin
                                n_changed = 1'b1;
                                o_we      = 1'b1;
                                o_waddr   = r_count[AW-1:0];
                                o_wdata   = r_t;
                                if (r_count == '0) begin
                                    n_head = r_t;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (r_found) begin
                            n_changed = 1'b1;
                            n_up      = 1'b0;
                            n_src     = r_pos + AW'(1);
                            n_left    = cnt_m1 - CW'(r_pos);
                            n_state   = S_MOVE;
                        end
                    end
                    OP_ROTATE: begin
                        n_present = 1'b0;
                        if (r_count > CW'(1)) begin
                            // keep the old head for the tail write
                            n_t       = r_head;
                            n_changed = 1'b1;
                            n_up      = 1'b0;
                            n_src     = AW'(1);
                            n_left    = cnt_m1;
                            n_state   = S_MOVE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MOVE: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_up ? (r_paddr + AW'(1)) : (r_paddr - AW'(1));
                    o_wdata = i_rdata;
                    if (o_waddr == '0) begin
                        n_head = i_rdata;
                    end
                end
                if (r_left != '0) begin
                    o_raddr = r_src;
                    n_paddr = r_src;
                    n_pend  = 1'b1;
                    n_src   = r_up ? (r_src - AW'(1)) : (r_src + AW'(1));
                    n_left  = r_left - CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                n_state = S_RESP;
                case (r_op)
                    OP_PUSH_HEAD: begin
                        o_we    = 1'b1;
                        o_waddr = '0;
                        o_wdata = r_t;
                        n_head  = r_t;
                        n_count = r_count + CW'(1);
                    end
                    OP_ROTATE: begin
                        o_we    = 1'b1;
                        o_waddr = cnt_m1[AW-1:0];
                        o_wdata = r_t;
                    end
                    OP_REMOVE: begin
                        n_count = cnt_m1;
                    end
                    default: begin
                    end
                endcase
            end
            S_RESP: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_op      <= n_op;
        r_t       <= n_t;
        r_head    <= n_head;
        r_idx     <= n_idx;
        r_paddr   <= n_paddr;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_src     <= n_src;
        r_left    <= n_left;
        r_up      <= n_up;
        r_present <= n_present;
        r_changed <= n_changed;
        r_reject  <= n_reject;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP) && i_res_free;

    always_comb begin
        o_res.was_present = r_present;
        o_res.changed     = r_changed;
        o_res.full_reject = r_reject;
        o_res.head_valid  = (r_count != '0);
        o_res.head_task   = (r_count != '0) ? head_ext[7:0] : 8'd0;
        o_res.entry_count = cnt_ext[4:0];
    end

endmodule

### rtl/ordered_task_set_top.sv
// Ordered task set (run queue) top level. An input beat goes through a scan of the count
// entries, a decide step and, where entries move, a shift of up to count entries and a tail
// step before its result is registered. One item at a time, set by the single read port.
// The input is stalled while busy.
// Reset (synchronous, active low) empties the list and drops any waiting result; the entry
// store is not cleared, only entries below the count are read. Uses otset_seq, otset_ram.
module ordered_task_set_top #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  otset_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output otset_pkg::t_out o_out_data
);
    import otset_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic               seq_busy;
    logic               seq_done;
    t_out               seq_res;
    logic               res_free;
    logic [AW-1:0]      ram_raddr;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ID_BITS-1:0] ram_wdata;
    logic [ID_BITS-1:0] ram_rdata;

    logic               r_out_vld;
    t_out               r_out;

    // Hold the input whenever the sequencer is at work on an item.
    assign o_in_stall = seq_busy;

    // The result register is free when empty or when its beat leaves this cycle.
    assign res_free = !r_out_vld || !i_out_stall;

    otset_seq #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && !seq_busy),
        .i_item     (i_in_data),
        .i_res_free (res_free),
        .o_busy     (seq_busy),
        .o_done     (seq_done),
        .o_res      (seq_res),
        .o_raddr    (ram_raddr),
        .i_rdata    (ram_rdata),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata)
    );

    otset_ram #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_raddr (ram_raddr),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Result register: load a finished beat, drop it once taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (seq_done) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (seq_done) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### sim/otset_checker.sv
// Checker for the ordered task set: watches both channels, predicts every answer beat
// from its own copy of the task list and compares it field by field with the block.
// Depends on otset_pkg for the beat types and the opcode codes.
module otset_checker #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  otset_pkg::t_in  i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  otset_pkg::t_out i_out_data,
    output int              o_fail_count,
    output int              o_pending
);
    import otset_pkg::*;

    logic [7:0] run_list [DEPTH];
    int         list_len;
    t_out       expected_answers [$];
    int         fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_answers.size();

    // Apply one operation to the shadow list and return the answer it should give.
    function automatic t_out apply_list_op(input t_in beat);
        t_out       ans;
        int         pos;
        int         i;
        logic [7:0] old_head;
        ans = '0;
        pos = -1;
        for (i = 0; i < list_len; i++) begin
            if (pos < 0 && run_list[i] == beat.task_id) pos = i;
        end
        ans.was_present = (pos >= 0);
        case (beat.opcode)
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                if (pos < 0) begin
                    if (list_len >= DEPTH) begin
                        ans.full_reject = 1'b1;
                    end else begin
                        if (beat.opcode == OP_PUSH_HEAD) begin
                            for (i = list_len; i > 0; i--) run_list[i] = run_list[i-1];
                            run_list[0] = beat.task_id;
                        end else begin
                            run_list[list_len] = beat.task_id;
                        end
                        list_len++;
                        ans.changed = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (pos >= 0) begin
                    for (i = pos; i + 1 < list_len; i++) run_list[i] = run_list[i+1];
                    list_len--;
                    ans.changed = 1'b1;
                end
            end
            OP_ROTATE: begin
                ans.was_present = 1'b0;
                if (list_len >= 2) begin
                    old_head = run_list[0];
                    for (i = 0; i < list_len - 1; i++) run_list[i] = run_list[i+1];
                    run_list[list_len-1] = old_head;
                    ans.changed = 1'b1;
                end
            end
            default: begin
            end
        endcase
        ans.head_valid  = (list_len > 0);
        ans.head_task   = (list_len > 0) ? run_list[0] : 8'd0;
        ans.entry_count = 5'(list_len);
        return ans;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        list_len   = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_answers.delete();
        end else begin
            // check the answer first, then log the new request
            if (i_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: answer beat with nothing expected, actual %h",
                             $time, i_out_data);
                    fail_count++;
                end else begin
                    want = expected_answers.pop_front();
                    if (i_out_data.was_present !== want.was_present)
                        report_field("was_present", want.was_present,
                                     i_out_data.was_present);
                    if (i_out_data.changed !== want.changed)
                        report_field("changed", want.changed, i_out_data.changed);
                    if (i_out_data.full_reject !== want.full_reject)
                        report_field("full_reject", want.full_reject,
                                     i_out_data.full_reject);
                    if (i_out_data.head_valid !== want.head_valid)
                        report_field("head_valid", want.head_valid, i_out_data.head_valid);
                    if (i_out_data.head_task !== want.head_task)
                        report_field("head_task", want.head_task, i_out_data.head_task);
                    if (i_out_data.entry_count !== want.entry_count)
                        report_field("entry_count", want.entry_count,
                                     i_out_data.entry_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_answers.push_back(apply_list_op(i_in_data));
            end
        end
    end

endmodule

### sim/tb_ordered_task_set_top.sv
// Testbench top for the ordered task set: clock, reset, request stimulus and verdict.
// Depends on otset_pkg, ordered_task_set_top and otset_checker, which does all checking.
module tb_ordered_task_set_top;
    import otset_pkg::*;

    localparam int DEPTH        = 16;
    // Spare opcodes that the block treats as a query.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    // Wait after the last answer, with a wide margin over the slowest request and stalls.
    localparam int DRAIN_CYCLES = 4 * DEPTH + 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1700;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in_data   = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_out  o_out_data;

    int    chk_fail;
    int    chk_pending;
    int    sender_idle_pct = 14;
    int    receiver_stall_pct = 59;
    int    cycle_count;

    always #10 i_clk = ~i_clk;

    ordered_task_set_top #(
        .DEPTH   (DEPTH),
        .ID_BITS (8)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    otset_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (chk_fail),
        .o_pending    (chk_pending)
    );

    // Receiver: stall at random, one fresh decision every cycle, whatever the block is doing.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Send one request beat: idle at random first, then hold the beat until it is taken.
    // Valid is only ever set once per edge, so back-to-back beats keep it high.
    task automatic send_beat(input logic [2:0] opcode, input logic [7:0] task_id);
        t_in beat;
        beat.opcode  = opcode;
        beat.task_id = task_id;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Random request: a fill bias favours pushes so the list reaches full, a drain bias
    // favours removes so it empties again. Most ids come from a narrow pool so that
    // pushes and removes hit present tasks; the rest span the whole id range.
    task automatic send_random(input bit fill_bias);
        int         pick;
        logic [2:0] opcode;
        logic [7:0] task_id;
        pick = $urandom_range(99);
        if (fill_bias) begin
            if (pick < 30)      opcode = OP_PUSH_HEAD;
            else if (pick < 60) opcode = OP_PUSH_TAIL;
            else if (pick < 72) opcode = OP_REMOVE;
            else if (pick < 86) opcode = OP_ROTATE;
            else if (pick < 96) opcode = OP_QUERY;
            else                opcode = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end else begin
            if (pick < 12)      opcode = OP_PUSH_HEAD;
            else if (pick < 24) opcode = OP_PUSH_TAIL;
            else if (pick < 70) opcode = OP_REMOVE;
            else if (pick < 84) opcode = OP_ROTATE;
            else if (pick < 96) opcode = OP_QUERY;
            else                opcode = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        if ($urandom_range(99) < 80) task_id = 8'($urandom_range(31));
        else                         task_id = 8'($urandom_range(255));
        send_beat(opcode, task_id);
    endtask

    // Timeout guard: count cycles and stop the run if it has hung.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_ordered_task_set_top: errors");
        $finish;
    end

    initial begin
        int phase;
        int n;
        // hold reset low from the start, then release
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty list, single entry, two entries, full list.
        send_beat(OP_SPARE_LO, 8'h00);        // spare opcode on empty list acts as query
        send_beat(OP_ROTATE, 8'hAA);          // rotate on empty list, id ignored
        send_beat(OP_REMOVE, 8'h55);          // remove of an absent task
        send_beat(OP_PUSH_HEAD, 8'h00);       // lowest id
        send_beat(OP_ROTATE, 8'hFF);          // rotate on a single entry leaves it alone
        send_beat(OP_PUSH_TAIL, 8'hFF);       // highest id
        send_beat(OP_PUSH_HEAD, 8'h00);       // push of a present task
        send_beat(OP_ROTATE, 8'h00);          // rotate on two entries
        for (n = 1; n <= DEPTH - 2; n++) send_beat(OP_PUSH_TAIL, 8'(n));
        send_beat(OP_PUSH_HEAD, 8'd200);      // absent task into full list: refused
        send_beat(OP_PUSH_TAIL, 8'hFF);       // present task into full list: no refusal
        send_beat(OP_ROTATE, 8'h00);          // rotate a full list
        send_beat(OP_REMOVE, 8'hFF);
        send_beat(OP_SPARE_HI, 8'h01);

        // Random part in three stretches: slow receiver, slow sender, then no idling.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    <= 14;
                    receiver_stall_pct <= 59;
                end
                1: begin
                    sender_idle_pct    <= 59;
                    receiver_stall_pct <= 14;
                end
                default: begin
                    sender_idle_pct    <= 0;
                    receiver_stall_pct <= 0;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
                // swap between filling and draining every forty beats
                send_random(((n / 40) % 2) == 0);
            end
        end
        i_in_valid <= 1'b0;

        // Drain: wait for every answer, then let the block settle.
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (chk_fail == 0 && chk_pending == 0) begin
            $display("tb_ordered_task_set_top: clean");
        end else begin
            $display("tb_ordered_task_set_top: errors");
        end
        $finish;
    end

endmodule
